>>> hw/rtl/key_max_hash_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key maximum hash table
// Concurrent assertion helpers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef KEY_MAX_HASH_TABLE_UNIT_MACROS_SVH
`define KEY_MAX_HASH_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define KMHT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define KMHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KMHT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define KMHT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/kmht_pkg.sv
// ----------------------------------------------------------------------------
// Key maximum hash table package
// Field widths and the multiplicative hash constant.
// ----------------------------------------------------------------------------
package kmht_pkg;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 13;
  localparam int TOTAL_W = 56;

  // Golden-ratio multiplier; only its low bits reach the slot index.
  localparam logic [KEY_W-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

endpackage

>>> hw/rtl/kmht_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module kmht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/key_max_hash_table_unit.sv
// ----------------------------------------------------------------------------
// Key maximum hash table
// Keeps the largest value seen per 64-bit key in a linear-probing table.
// ----------------------------------------------------------------------------
// Each request carries a 64-bit key and a 32-bit value; the block keeps, per
// distinct key, the largest value seen and returns one result per request:
// whether the key was new, the maximum now held for it, the number of
// distinct keys and the running sum of all maxima. Keys live in an
// open-addressing table of TABLE_SLOTS slots (a power of two); the home slot
// is the low bits of key * 0x9E3779B97F4A7C15 and probing is linear with
// wrap-around. Key zero marks an empty slot, so key zero itself is kept in a
// side register. The table never grows: a new key that finds no free slot is
// dropped and reported with status set. After reset the block clears every
// slot of the key memory and stalls requests meanwhile. A request for key
// zero goes from idle straight to the update state; any other key passes
// through read, then one check per slot probed (the home slot alone when
// it hits or is free, up to TABLE_SLOTS when the table is full), then update.
// The key memory's single read port sets the probe rate: one slot per cycle.
// One request is worked on at a time; the result sits in an output register,
// so the next request is taken while an earlier result is still stalled.
// ----------------------------------------------------------------------------
`include "key_max_hash_table_unit_macros.svh"

module key_max_hash_table_unit import kmht_pkg::*; #(
  parameter int TABLE_SLOTS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KEY_W-1:0]   key_hash,
  input  logic [VAL_W-1:0]   obj_bytes,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic               is_new_key,
  output logic [VAL_W-1:0]   stored_max,
  output logic [COUNT_W-1:0] distinct_keys,
  output logic [TOTAL_W-1:0] total_of_maxima
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] MULT_LOW = HASH_MULT[IDX_W-1:0];
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_UPDATE,
    S_HOLD
  } state_t;

  state_t state;

  // Control registers.
  logic [IDX_W-1:0]   clr_addr;
  logic               zero_present;
  logic [VAL_W-1:0]   zero_max;
  logic [COUNT_W-1:0] occupied_count;
  logic [TOTAL_W-1:0] running_total;

  // Request being worked on.
  key_t             req_key;
  val_t             req_val;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] probe;
  val_t             upd_old;
  logic             upd_new;
  logic             upd_zero;
  logic             upd_full;

  // Held result when the output register is still occupied.
  logic               res_status;
  logic               res_new;
  val_t               res_max;
  logic [COUNT_W-1:0] res_distinct;
  logic [TOTAL_W-1:0] res_total;

  // Memory ports.
  logic             key_wr_en;
  logic [IDX_W-1:0] key_wr_addr;
  key_t             key_wr_data;
  key_t             key_rd_data;
  logic             val_wr_en;
  val_t             val_rd_data;
  logic [IDX_W-1:0] rd_addr;

  // Datapath.
  logic [IDX_W-1:0]   home_idx;
  logic [IDX_W-1:0]   idx_inc;
  logic               slot_hit;
  logic               slot_empty;
  logic               grow;
  val_t               delta;
  val_t               new_max;
  logic               table_insert;
  logic [TOTAL_W-1:0] total_next;
  logic [COUNT_W-1:0] count_next;
  logic               zero_present_next;
  logic [COUNT_W-1:0] distinct_next;
  logic               out_free;
  logic               out_load;

  // Only the low index bits of the product matter, so a narrow multiply does.
  assign home_idx   = key_hash[IDX_W-1:0] * MULT_LOW;
  assign idx_inc    = idx + 1'b1;
  assign slot_hit   = (key_rd_data == req_key);
  assign slot_empty = (key_rd_data == '0);
  assign out_free   = !out_valid || !out_stall;
  assign out_load   = out_free && (state == S_UPDATE || state == S_HOLD);
  assign in_stall   = (state != S_IDLE);

  always_comb begin
    grow  = (req_val > upd_old);
    delta = '0;
    new_max = '0;
    if (!upd_full) begin
      if (upd_new) begin
        delta   = req_val;
        new_max = req_val;
      end else if (grow) begin
        delta   = req_val - upd_old;
        new_max = req_val;
      end else begin
        new_max = upd_old;
      end
    end
    table_insert      = upd_new && !upd_zero && !upd_full;
    total_next        = running_total + TOTAL_W'(delta);
    count_next        = occupied_count + COUNT_W'(table_insert);
    zero_present_next = zero_present || upd_zero;
    distinct_next     = count_next + COUNT_W'(zero_present_next);
  end

  // Memory control: the clearing pass owns the key write port after reset.
  always_comb begin
    key_wr_en   = 1'b0;
    key_wr_addr = idx;
    key_wr_data = req_key;
    rd_addr     = idx;
    case (state)
      S_CLEAR: begin
        key_wr_en   = 1'b1;
        key_wr_addr = clr_addr;
        key_wr_data = '0;
      end
      S_CHECK: begin
        rd_addr = idx_inc;
      end
      S_UPDATE: begin
        key_wr_en = table_insert;
      end
      default: begin
        key_wr_en = 1'b0;
      end
    endcase
    val_wr_en = (state == S_UPDATE) && !upd_zero && !upd_full && (upd_new || grow);
  end

  kmht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (key_wr_addr),
    .wr_data (key_wr_data),
    .rd_addr (rd_addr),
    .rd_data (key_rd_data)
  );

  kmht_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_SLOTS)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (idx),
    .wr_data (req_val),
    .rd_addr (rd_addr),
    .rd_data (val_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      zero_present   <= 1'b0;
      zero_max       <= '0;
      occupied_count <= '0;
      running_total  <= '0;
      out_valid      <= 1'b0;
    end else begin
      // A result loads whenever the output register is free; otherwise the
      // register empties once its result is taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_key  <= key_hash;
            req_val  <= obj_bytes;
            idx      <= home_idx;
            probe    <= '0;
            upd_full <= 1'b0;
            if (key_hash == '0) begin
              upd_zero <= 1'b1;
              upd_new  <= !zero_present;
              upd_old  <= zero_max;
              state    <= S_UPDATE;
            end else begin
              upd_zero <= 1'b0;
              state    <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (slot_hit) begin
            upd_new <= 1'b0;
            upd_old <= val_rd_data;
            state   <= S_UPDATE;
          end else if (slot_empty) begin
            upd_new <= 1'b1;
            state   <= S_UPDATE;
          end else if (probe == IDX_LAST) begin
            // Every slot probed without a match or a free slot.
            upd_new  <= 1'b1;
            upd_full <= 1'b1;
            state    <= S_UPDATE;
          end else begin
            idx   <= idx_inc;
            probe <= probe + 1'b1;
          end
        end
        S_UPDATE: begin
          running_total  <= total_next;
          occupied_count <= count_next;
          zero_present   <= zero_present_next;
          if (upd_zero) begin
            zero_max <= new_max;
          end
          res_status   <= upd_full;
          res_new      <= upd_new;
          res_max      <= new_max;
          res_distinct <= distinct_next;
          res_total    <= total_next;
          if (out_free) begin
            status          <= upd_full;
            is_new_key      <= upd_new;
            stored_max      <= new_max;
            distinct_keys   <= distinct_next;
            total_of_maxima <= total_next;
            state           <= S_IDLE;
          end else begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            status          <= res_status;
            is_new_key      <= res_new;
            stored_max      <= res_max;
            distinct_keys   <= res_distinct;
            total_of_maxima <= res_total;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A dropped key is always a new key and holds no maximum.
  `KMHT_ASSERT_IMPLIES(a_drop_result, clk, rst, out_valid && status, is_new_key && stored_max == '0)
  // The table fill count only ever grows by one slot per request.
  `KMHT_ASSERT_NEXT(a_count_step, clk, rst, 1'b1, occupied_count == $past(occupied_count) || occupied_count == COUNT_W'($past(occupied_count) + 1'b1))
  // Outside the clearing pass the key memory never receives the empty marker.
  `KMHT_ASSERT_IMPLIES(a_no_zero_key, clk, rst, key_wr_en && state != S_CLEAR, key_wr_data != '0)

endmodule
